// ===== rtl/fpba_pkg.sv =====
package fpba_pkg;

    localparam int MAX_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 16;
    localparam int POLICY_W = 2;
    localparam int COUNT_W  = 6;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W  = 24;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // placement rules; the unused code falls back to first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [COUNT_W-1:0]  count;
    } t_cfg;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] chosen;
        logic [VALUE_W-1:0] remaining;
    } t_res;

endpackage

// ===== rtl/fpba_table.sv =====
module fpba_table #(
    parameter int DEPTH = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int WIDTH = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    import fpba_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/fpba_ctrl.sv =====
module fpba_ctrl #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpba_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [fpba_pkg::INDEX_W-1:0]  i_index,
    input  logic [fpba_pkg::VALUE_W-1:0]  i_size,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_wr_addr,
    output logic [SIZE_BITS-1:0]          o_wr_data,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_rd_addr,
    input  logic [SIZE_BITS-1:0]          i_rd_data,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output fpba_pkg::t_res                o_res
);
    import fpba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_last, n_last;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic                 r_found, n_found;

    logic                 accept;
    logic [31:0]          limit;
    logic [SIZE_BITS-1:0] size_in;
    logic                 fits, take, first_mode, stop;
    logic [SIZE_BITS-1:0] left;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign size_in = SIZE_BITS'(i_size);
    assign limit   = (32'(i_cfg.count) > MAX_BLOCKS) ? 32'(MAX_BLOCKS) : 32'(i_cfg.count);

    // shared compare unit: one table entry per cycle
    assign first_mode = (i_cfg.policy != POL_BEST) && (i_cfg.policy != POL_WORST);
    assign fits = (i_rd_data >= r_req);
    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (i_cfg.policy == POL_BEST) begin
                take = (i_rd_data < r_best);
            end else if (i_cfg.policy == POL_WORST) begin
                take = (i_rd_data > r_best);
            end
        end
    end
    assign stop = (fits && first_mode) || (r_cnt == r_last);
    assign left = r_best - r_req;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_pick  = r_pick;
        n_best  = r_best;
        n_req   = r_req;
        n_found = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_opcode == OP_ALLOC)) begin
                    n_req   = size_in;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_pick  = '0;
                    n_last  = IDX_W'(limit - 32'd1);
                    n_state = (limit == 32'd0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (take) begin
                    n_found = 1'b1;
                    n_pick  = r_cnt;
                    n_best  = i_rd_data;
                end
                if (stop) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_pick <= n_pick;
        r_best <= n_best;
        r_req  <= n_req;
    end

    // read one ahead of the entry under test; the idle address primes entry zero
    always_comb begin
        if (r_state == S_SCAN && r_cnt != r_last) begin
            o_rd_addr = r_cnt + 1'b1;
        end else if (r_state == S_SCAN) begin
            o_rd_addr = r_cnt;
        end else begin
            o_rd_addr = '0;
        end
    end

    // table write: a load from idle, or the write-back of the granted block
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_pick;
        o_wr_data = left;
        if (r_state == S_IDLE) begin
            o_wr_en   = accept && (i_opcode == OP_LOAD) && (32'(i_index) < MAX_BLOCKS);
            o_wr_addr = IDX_W'(i_index);
            o_wr_data = size_in;
        end else if (r_state == S_DONE) begin
            o_wr_en = r_found && i_res_ready;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    always_comb begin
        o_res = '0;
        if (r_found) begin
            o_res.granted   = 1'b1;
            o_res.chosen    = INDEX_W'(r_pick);
            o_res.remaining = VALUE_W'(left);
        end
    end

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Block allocator with first, best and worst fit placement.
//
// Slave stream: tuser carries the opcode (load or allocate), tdata the block
// index and the size. A load writes one table entry in its accept cycle and
// gives no output beat, so the next beat can follow at once. An allocate
// scans entries 0 .. N-1, N being min(block_count, MAX_BLOCKS), one entry per
// cycle through the single read port of the table and one compare unit; the
// first entry is read at the accept edge and first fit stops at the first
// entry that fits. The result passes from the scan state to the result
// state and then into the output register; a block_count of zero skips
// the scan. The slave side is not ready during the scan or in the result
// state, and takes the next beat once the result state has handed on its result.
// Master stream: tuser is the grant flag, tdata the block and size left.
// A one-beat output register sits on the master side; a stalled master
// holds the result there and the sequencer waits in its result state
// while that register is full and unread. Configuration writes are always taken.
// Reset returns the sequencer to idle, the policy to first fit and the
// block count to one; the table is not cleared and entries must be loaded
// before use.
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [fpba_pkg::TDATA_W-1:0]    i_s_axis_tdata,  // block_index, size_value
    input  logic                            i_s_axis_tuser,  // opcode
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [fpba_pkg::TDATA_W-1:0]    o_m_axis_tdata,  // chosen_block, remaining_after
    output logic                            o_m_axis_tuser,  // granted
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpba_pkg::COUNT_W-1:0]    i_cfg_data
);
    import fpba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    t_cfg                 r_cfg;
    t_res                 r_out;
    logic                 r_out_valid;
    t_res                 res;
    logic                 res_valid, res_ready;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [SIZE_BITS-1:0] wr_data, rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy <= POL_FIRST;
            r_cfg.count  <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLICY: r_cfg.policy <= i_cfg_data[POLICY_W-1:0];
                CFG_COUNT:  r_cfg.count  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    fpba_table #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SIZE_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fpba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_index     (i_s_axis_tdata[INDEX_W-1:0]),
        .i_size      (i_s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.granted;
    assign o_m_axis_tdata  = {(TDATA_W-INDEX_W-VALUE_W)'(0), r_out.remaining, r_out.chosen};

    // a load never gives a beat
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_LOAD
            && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("output beat after a load");

    // an allocate holds off the slave side while it scans
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_ALLOC)
            |=> !o_s_axis_tready)
        else $error("slave ready during a scan");

    // a refused request reports zero block and zero size
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("refused request with non-zero data");

endmodule
